@@ rtl/idm_pkg.sv @@
package idm_pkg;

  localparam int unsigned FRAC_BITS_DEF = 8;

  localparam int unsigned POS_W     = 32;
  localparam int unsigned SPD_W     = 16;
  localparam int unsigned ACC_W     = 12;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned OUT_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // a*b is 24 bits wide, so its root has 12 bits.
  localparam int unsigned AB_W = 2 * ACC_W;
  localparam int unsigned SQ_W = ACC_W;

  localparam logic [ACC_W-1:0] MAX_ACCEL_RST     = 12'd384;
  localparam logic [ACC_W-1:0] COMFORT_DECEL_RST = 12'd512;
  localparam logic [SPD_W-1:0] DESIRED_SPEED_RST = 16'd7680;
  localparam logic [SPD_W-1:0] MIN_GAP_RST       = 16'd512;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_ACCEL     = 2'd0,
    CFG_COMFORT_DECEL = 2'd1,
    CFG_DESIRED_SPEED = 2'd2,
    CFG_MIN_GAP       = 2'd3
  } cfg_idx_e;

endpackage

@@ rtl/idm_if.sv @@
interface idm_in_if;
  logic                           valid;
  logic                           ready;
  logic [idm_pkg::POS_W-1:0]      own_position;
  logic [idm_pkg::SPD_W-1:0]      own_speed;
  logic [idm_pkg::POS_W-1:0]      lead_position;
  logic [idm_pkg::SPD_W-1:0]      lead_speed;

  modport source (output valid, own_position, own_speed, lead_position, lead_speed,
                  input ready);
  modport sink (input valid, own_position, own_speed, lead_position, lead_speed,
                output ready);
endinterface

interface idm_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [idm_pkg::OUT_W-1:0] accel_out;
  logic                           gap_invalid;
  logic                           saturated;

  modport source (output valid, accel_out, gap_invalid, saturated, input ready);
  modport sink (input valid, accel_out, gap_invalid, saturated, output ready);
endinterface

@@ rtl/idm_div.sv @@
module idm_div #(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 16,
  parameter int unsigned QW = 12,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [NW-1:0] n_i,
  input  logic [DW-1:0] d_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [QW-1:0] q_o,
  output logic [SW-1:0] side_o
);

  // Restoring division, one quotient bit per stage. The caller keeps n < d << QW.
  localparam int unsigned W = (NW > DW + QW) ? NW : DW + QW;

  logic [W-1:0]  rem_q  [QW];
  logic [DW-1:0] den_q  [QW];
  logic [QW-1:0] quo_q  [QW];
  logic [SW-1:0] side_q [QW];
  logic          vld_q  [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [W-1:0]  rem_in;
    logic [W-1:0]  dsh;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [SW-1:0] side_in;
    logic          vld_in;
    logic          take;

    if (s == 0) begin : g_first
      assign rem_in  = W'(n_i);
      assign den_in  = d_i;
      assign quo_in  = '0;
      assign side_in = side_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign side_in = side_q[s-1];
      assign vld_in  = vld_q[s-1];
    end

    assign dsh  = W'(den_in) << (QW - 1 - s);
    assign take = (rem_in >= dsh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= take ? (rem_in - dsh) : rem_in;
        den_q[s]  <= den_in;
        quo_q[s]  <= (quo_in << 1) | QW'(take);
        side_q[s] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[QW-1];
  assign q_o    = quo_q[QW-1];
  assign side_o = side_q[QW-1];

endmodule

@@ rtl/idm_sqrt.sv @@
module idm_sqrt #(
  parameter int unsigned SW = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      vld_i,
  input  logic [idm_pkg::AB_W-1:0]  x_i,
  input  logic [SW-1:0]             side_i,
  output logic                      vld_o,
  output logic [idm_pkg::SQ_W-1:0]  sq_o,
  output logic [SW-1:0]             side_o
);

  localparam int unsigned XW = idm_pkg::AB_W;
  localparam int unsigned NS = idm_pkg::SQ_W;

  // Digit-by-digit integer root, one result bit per stage.
  logic [XW-1:0] x_q    [NS];
  logic [XW-1:0] res_q  [NS];
  logic [SW-1:0] side_q [NS];
  logic          vld_q  [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [XW-1:0] x_in;
    logic [XW-1:0] res_in;
    logic [XW-1:0] bit_w;
    logic [XW-1:0] trial;
    logic [SW-1:0] side_in;
    logic          vld_in;
    logic          take;

    if (s == 0) begin : g_first
      assign x_in    = x_i;
      assign res_in  = '0;
      assign side_in = side_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign x_in    = x_q[s-1];
      assign res_in  = res_q[s-1];
      assign side_in = side_q[s-1];
      assign vld_in  = vld_q[s-1];
    end

    assign bit_w = XW'(1) << (2 * (NS - 1 - s));
    assign trial = res_in + bit_w;
    assign take  = (x_in >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[s]    <= take ? (x_in - trial) : x_in;
        res_q[s]  <= take ? ((res_in >> 1) + bit_w) : (res_in >> 1);
        side_q[s] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[NS-1];
  assign sq_o   = res_q[NS-1][NS-1:0];
  assign side_o = side_q[NS-1];

endmodule

@@ rtl/idm_car_following_accel.sv @@
// Intelligent Driver Model acceleration for one follower/leader pair per item.
// The block is a single pipeline that takes a new item in every cycle unless
// the output stalls, and returns one result per item, in order. Its main
// stages are the three bit-per-stage
// dividers (v/v0, the dynamic gap term and s*/gap) and the 12-stage root of
// a*b, all in series. A stall at the output holds the whole pipeline.
// Configuration may be written only while no item is in flight.
module idm_car_following_accel #(
  parameter int unsigned FRAC_BITS = idm_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  idm_in_if.sink                        items_i,
  idm_out_if.source                     results_o,
  input  logic                          cfg_we_i,
  input  logic [idm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [idm_pkg::CFG_W-1:0]     cfg_wdata_i
);

  localparam int unsigned F       = FRAC_BITS;
  localparam int unsigned POS_W   = idm_pkg::POS_W;
  localparam int unsigned SPD_W   = idm_pkg::SPD_W;
  localparam int unsigned ACC_W   = idm_pkg::ACC_W;
  localparam int unsigned OUT_W   = idm_pkg::OUT_W;
  localparam int unsigned VN_W    = SPD_W + F;
  localparam int unsigned R_W     = 4 + F;
  localparam int unsigned R2_W    = 8 + F;
  localparam int unsigned TERM_W  = 17 + F;
  localparam int unsigned DEN_W   = idm_pkg::SQ_W + 1;
  localparam int unsigned ND_W    = 2 * SPD_W;
  localparam int unsigned DYN_W   = ND_W - 1;
  localparam int unsigned QN_W    = POS_W + F;
  localparam int unsigned Q_W     = 8 + F;
  localparam int unsigned INNER_W = TERM_W + 2;
  localparam int unsigned PROD_W  = INNER_W + ACC_W + 1;

  localparam logic [TERM_W-1:0] ONE_VAL = TERM_W'(1) << F;
  localparam logic [TERM_W-1:0] CAP_VAL = TERM_W'(1) << (16 + F);

  typedef struct packed {
    logic               inv;
    logic [POS_W-1:0]   gap;
    logic [SPD_W-1:0]   v;
    logic               dneg;
    logic [SPD_W-1:0]   dmag;
    logic [idm_pkg::AB_W-1:0] ab;
    logic               rsat;
  } s1_t;

  typedef struct packed {
    logic               inv;
    logic [POS_W-1:0]   gap;
    logic [SPD_W-1:0]   v;
    logic               dneg;
    logic [SPD_W-1:0]   dmag;
    logic [TERM_W-1:0]  free;
  } rt_t;

  typedef struct packed {
    logic               inv;
    logic [POS_W-1:0]   gap;
    logic [SPD_W-1:0]   v;
    logic               dneg;
    logic [TERM_W-1:0]  free;
  } dy_t;

  typedef struct packed {
    logic               inv;
    logic [TERM_W-1:0]  free;
    logic               qsat;
  } qs_t;

  // Configuration registers.
  logic [ACC_W-1:0] max_accel_q;
  logic [ACC_W-1:0] comfort_decel_q;
  logic [SPD_W-1:0] desired_speed_q;
  logic [SPD_W-1:0] min_gap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_accel_q     <= idm_pkg::MAX_ACCEL_RST;
      comfort_decel_q <= idm_pkg::COMFORT_DECEL_RST;
      desired_speed_q <= idm_pkg::DESIRED_SPEED_RST;
      min_gap_q       <= idm_pkg::MIN_GAP_RST;
    end else if (cfg_we_i) begin
      case (idm_pkg::cfg_idx_e'(cfg_idx_i))
        idm_pkg::CFG_MAX_ACCEL:     max_accel_q     <= cfg_wdata_i[ACC_W-1:0];
        idm_pkg::CFG_COMFORT_DECEL: comfort_decel_q <= cfg_wdata_i[ACC_W-1:0];
        idm_pkg::CFG_DESIRED_SPEED: desired_speed_q <= cfg_wdata_i;
        idm_pkg::CFG_MIN_GAP:       min_gap_q       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_vld_q;

  assign en            = !out_vld_q || results_o.ready;
  assign items_i.ready = en;

  logic [SPD_W-1:0] v0e;
  assign v0e = (desired_speed_q == '0) ? SPD_W'(1) : desired_speed_q;

  // Stage 1: gap, speed difference, a*b and the free-road overflow check.
  s1_t  s1_d, s1_q;
  logic s1_vld_q;

  always_comb begin
    s1_d.inv  = (items_i.lead_position <= items_i.own_position);
    s1_d.gap  = items_i.lead_position - items_i.own_position;
    s1_d.v    = items_i.own_speed;
    s1_d.dneg = (items_i.lead_speed > items_i.own_speed);
    s1_d.dmag = s1_d.dneg ? (items_i.lead_speed - items_i.own_speed)
                          : (items_i.own_speed - items_i.lead_speed);
    s1_d.ab   = max_accel_q * comfort_decel_q;
    // v/v0 >= 16 exactly when v >= 16*v0.
    s1_d.rsat = ({4'b0, items_i.own_speed} >= {v0e, 4'b0});
  end

  // v/v0 division.
  logic             dr_vld;
  logic [R_W-1:0]   dr_q;
  logic [$bits(s1_t)-1:0] dr_side;
  s1_t              dr_s;

  idm_div #(.NW(VN_W), .DW(SPD_W), .QW(R_W), .SW($bits(s1_t))) u_div_ratio (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s1_vld_q),
    .n_i    ({s1_q.v, F'(0)}),
    .d_i    (v0e),
    .side_i (s1_q),
    .vld_o  (dr_vld),
    .q_o    (dr_q),
    .side_o (dr_side)
  );
  assign dr_s = dr_side;

  // Free-road term: two squaring stages.
  logic [2*R_W-1:0]  rr;
  logic [R2_W-1:0]   r2_q;
  s1_t               f1_q;
  logic              f1_vld_q;
  logic [2*R2_W-1:0] rr2;
  rt_t               f2_d, f2_q;
  logic              f2_vld_q;
  logic [idm_pkg::AB_W-1:0] f1_ab_q;

  assign rr  = dr_q * dr_q;
  assign rr2 = r2_q * r2_q;

  always_comb begin
    f2_d.inv  = f1_q.inv;
    f2_d.gap  = f1_q.gap;
    f2_d.v    = f1_q.v;
    f2_d.dneg = f1_q.dneg;
    f2_d.dmag = f1_q.dmag;
    f2_d.free = f1_q.rsat ? CAP_VAL : TERM_W'(rr2 >> F);
  end

  // Root of a*b.
  logic                     sq_vld;
  logic [idm_pkg::SQ_W-1:0] sq;
  logic [$bits(rt_t)-1:0]   sq_side;
  rt_t                      sq_s;

  idm_sqrt #(.SW($bits(rt_t))) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (f2_vld_q),
    .x_i    (f1_ab_q),
    .side_i (f2_q),
    .vld_o  (sq_vld),
    .sq_o   (sq),
    .side_o (sq_side)
  );
  assign sq_s = sq_side;

  // Numerator v*|v-vl| and denominator 2*sqrt(a*b).
  logic [ND_W-1:0]  nd_q;
  logic [DEN_W-1:0] den_q;
  dy_t              d0_q;
  logic             d0_vld_q;
  logic [idm_pkg::SQ_W-1:0] sqe;

  assign sqe = (sq == '0) ? idm_pkg::SQ_W'(1) : sq;

  logic             dd_vld;
  logic [DYN_W-1:0] dyn;
  logic [$bits(dy_t)-1:0] dd_side;
  dy_t              dd_s;

  idm_div #(.NW(ND_W), .DW(DEN_W), .QW(DYN_W), .SW($bits(dy_t))) u_div_dyn (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (d0_vld_q),
    .n_i    (nd_q),
    .d_i    (den_q),
    .side_i (d0_q),
    .vld_o  (dd_vld),
    .q_o    (dyn),
    .side_o (dd_side)
  );
  assign dd_s = dd_side;

  // Desired gap magnitude |s0 + 2v +/- dyn|.
  logic [POS_W-1:0] posw;
  logic [POS_W-1:0] dynw;
  logic [POS_W-1:0] smag_d, smag_q;
  logic [POS_W-1:0] sg_gap_q;
  logic [TERM_W-1:0] sg_free_q;
  logic             sg_inv_q;
  logic             sg_vld_q;

  assign posw = POS_W'(min_gap_q) + POS_W'({dd_s.v, 1'b0});
  assign dynw = POS_W'(dyn);

  always_comb begin
    if (!dd_s.dneg) begin
      smag_d = posw + dynw;
    end else if (dynw > posw) begin
      smag_d = dynw - posw;
    end else begin
      smag_d = posw - dynw;
    end
  end

  // s*/gap division; the overflow check rides along as side data.
  qs_t qs_in;
  assign qs_in.inv  = sg_inv_q;
  assign qs_in.free = sg_free_q;
  assign qs_in.qsat = ({8'b0, smag_q} >= {sg_gap_q, 8'b0});

  logic            dq_vld;
  logic [Q_W-1:0]  q;
  logic [$bits(qs_t)-1:0] dq_side;
  qs_t             dq_s;

  idm_div #(.NW(QN_W), .DW(POS_W), .QW(Q_W), .SW($bits(qs_t))) u_div_gap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (sg_vld_q),
    .n_i    ({smag_q, F'(0)}),
    .d_i    (sg_gap_q),
    .side_i (qs_in),
    .vld_o  (dq_vld),
    .q_o    (q),
    .side_o (dq_side)
  );
  assign dq_s = dq_side;

  // Interaction term, inner sum, scaling by a, then saturation.
  logic [2*Q_W-1:0]  qq;
  logic [TERM_W-1:0] inter_q;
  logic [TERM_W-1:0] i1_free_q;
  logic              i1_inv_q;
  logic              i1_vld_q;
  logic signed [INNER_W-1:0] inner_q;
  logic              i2_inv_q;
  logic              i2_vld_q;
  logic signed [PROD_W-1:0] prod_q;
  logic              i3_inv_q;
  logic              i3_vld_q;

  assign qq = q * q;

  logic              pneg;
  logic [PROD_W-1:0] pmag;
  logic [PROD_W-1:0] amag;
  logic [OUT_W-1:0]  acc_d, acc_q;
  logic              sat_d, sat_q;
  logic              inv_q;

  always_comb begin
    pneg = prod_q[PROD_W-1];
    pmag = pneg ? PROD_W'(-prod_q) : PROD_W'(prod_q);
    amag = pmag >> F;
    if (i3_inv_q) begin
      acc_d = {1'b1, {(OUT_W-1){1'b0}}};
      sat_d = 1'b1;
    end else if (!pneg && amag > PROD_W'(32767)) begin
      acc_d = {1'b0, {(OUT_W-1){1'b1}}};
      sat_d = 1'b1;
    end else if (pneg && amag > PROD_W'(32768)) begin
      acc_d = {1'b1, {(OUT_W-1){1'b0}}};
      sat_d = 1'b1;
    end else begin
      acc_d = pneg ? (~amag[OUT_W-1:0] + OUT_W'(1)) : amag[OUT_W-1:0];
      sat_d = 1'b0;
    end
  end

  // Valid bits of the stages kept in this module.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      f1_vld_q  <= 1'b0;
      f2_vld_q  <= 1'b0;
      d0_vld_q  <= 1'b0;
      sg_vld_q  <= 1'b0;
      i1_vld_q  <= 1'b0;
      i2_vld_q  <= 1'b0;
      i3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= items_i.valid;
      f1_vld_q  <= dr_vld;
      f2_vld_q  <= f1_vld_q;
      d0_vld_q  <= sq_vld;
      sg_vld_q  <= dd_vld;
      i1_vld_q  <= dq_vld;
      i2_vld_q  <= i1_vld_q;
      i3_vld_q  <= i2_vld_q;
      out_vld_q <= i3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q      <= s1_d;
      r2_q      <= R2_W'(rr >> F);
      f1_q      <= dr_s;
      f1_ab_q   <= dr_s.ab;
      f2_q      <= f2_d;
      nd_q      <= sq_s.v * sq_s.dmag;
      den_q     <= {sqe, 1'b0};
      d0_q.inv  <= sq_s.inv;
      d0_q.gap  <= sq_s.gap;
      d0_q.v    <= sq_s.v;
      d0_q.dneg <= sq_s.dneg;
      d0_q.free <= sq_s.free;
      smag_q    <= smag_d;
      sg_gap_q  <= dd_s.gap;
      sg_free_q <= dd_s.free;
      sg_inv_q  <= dd_s.inv;
      inter_q   <= dq_s.qsat ? CAP_VAL : TERM_W'(qq >> F);
      i1_free_q <= dq_s.free;
      i1_inv_q  <= dq_s.inv;
      inner_q   <= $signed(INNER_W'(ONE_VAL)) - $signed(INNER_W'(i1_free_q))
                   - $signed(INNER_W'(inter_q));
      i2_inv_q  <= i1_inv_q;
      prod_q    <= $signed({1'b0, max_accel_q}) * inner_q;
      i3_inv_q  <= i2_inv_q;
      acc_q     <= acc_d;
      sat_q     <= sat_d;
      inv_q     <= i3_inv_q;
    end
  end

  assign results_o.valid       = out_vld_q;
  assign results_o.accel_out   = $signed(acc_q);
  assign results_o.gap_invalid = inv_q;
  assign results_o.saturated   = sat_q;

endmodule
